[rtl/sparse_matrix_multiply_trace_macros.svh]
// assertion macros shared by the matrix engine modules
// no dependencies
`ifndef SPARSE_MATRIX_MULTIPLY_TRACE_MACROS_SVH
`define SPARSE_MATRIX_MULTIPLY_TRACE_MACROS_SVH
// implication checked every clock outside reset
`define SMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication whose consequence is checked in the cycle after the antecedent
`define SMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[rtl/smm_pkg.sv]
// shared types and constants of the sparse matrix engine
// no dependencies
package smm_pkg;
	localparam int MaxDim = 64;
	localparam int IdxBits = $clog2(MaxDim);
	localparam int AddrBits = 2 * IdxBits;
	localparam int ElemBits = 16;
	localparam int AccBits = 48;
	localparam int DimBits = 7;

	typedef enum logic [2:0] {
		REQ_WR_A  = 3'd0,
		REQ_WR_B  = 3'd1,
		REQ_MUL   = 3'd2,
		REQ_RD_C  = 3'd3,
		REQ_TRACE = 3'd4,
		REQ_CLEAR = 3'd5,
		REQ_RSV6  = 3'd6,
		REQ_RSV7  = 3'd7
	} req_t;

	typedef enum logic {
		CFG_ROWS = 1'b0,
		CFG_COLS = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		req_t                        kind;
		logic [IdxBits-1:0]          row;
		logic [IdxBits-1:0]          col;
		logic signed [ElemBits-1:0]  value;
	} item_t;

	// dimension above the store size counts as the store size
	function automatic logic [DimBits-1:0] clamp_dim(input logic [DimBits-1:0] d);
		clamp_dim = (d > DimBits'(MaxDim)) ? DimBits'(MaxDim) : d;
	endfunction
endpackage

[rtl/smm_front.sv]
// front end: accepts items into a two-entry queue
// depends on smm_pkg
module smm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  smm_pkg::item_t      push_item,
	input  logic                pop,
	output logic                full,
	output logic                head_valid,
	output smm_pkg::item_t      head_item
);
	smm_pkg::item_t mem_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_item = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

`include "sparse_matrix_multiply_trace_macros.svh"
	`SMM_ASSERT_IMP(a_no_overflow, clk, arst_n, full, !push || pop || cnt_q == 2'd2)
	`SMM_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q != 2'd3)
	`SMM_ASSERT_NEXT(a_pop_only_valid, clk, arst_n, do_pop && !do_push && cnt_q == 2'd1,
		!head_valid)
endmodule

[rtl/smm_back.sv]
// back end: stores of A, B and C and the sequencer that runs each item
// depends on smm_pkg
module smm_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_valid,
	input  smm_pkg::item_t                    head_item,
	output logic                              pop,
	input  logic [smm_pkg::DimBits-1:0]       dim_rows,
	input  logic [smm_pkg::DimBits-1:0]       dim_cols,
	output logic                              done,
	output logic signed [smm_pkg::AccBits-1:0] result_value,
	output logic                              saturated
);
	localparam int AB = smm_pkg::AddrBits;
	localparam int IB = smm_pkg::IdxBits;
	localparam int DB = smm_pkg::DimBits;
	localparam int EB = smm_pkg::ElemBits;
	localparam int CB = smm_pkg::AccBits;
	localparam int PB = 2 * EB;

	typedef enum logic [3:0] {
		S_CLR_ALL, S_IDLE, S_CLR_C, S_MA, S_MA_W, S_MB, S_MB_W, S_MC,
		S_RD, S_RD_W, S_TR, S_TR_W
	} state_t;

	logic signed [EB-1:0] a_mem [2**AB];
	logic signed [EB-1:0] b_mem [2**AB];
	logic [CB:0]          c_mem [2**AB];

	state_t state_q;
	logic [AB-1:0] clr_q;
	logic [DB-1:0] i_q, k_q, j_q;
	logic [IB-1:0] rrow_q, rcol_q;
	logic signed [EB-1:0] av_q;
	logic signed [PB-1:0] prod_q;
	logic signed [CB-1:0] sum_q;
	logic hit_q;
	logic done_q;
	logic signed [CB-1:0] res_q;
	logic sat_q;

	logic [DB-1:0] rows, cols;
	logic a_we, b_we, c_we;
	logic [AB-1:0] a_addr, b_addr, c_addr;
	logic signed [EB-1:0] a_wd, b_wd, a_rd, b_rd;
	logic [CB:0] c_wd, c_rd;
	logic signed [CB:0] mac_sum, tr_sum;
	logic signed [CB-1:0] mac_val, tr_val;
	logic mac_ovf, tr_ovf;
	logic take;

	assign rows = smm_pkg::clamp_dim(dim_rows);
	assign cols = smm_pkg::clamp_dim(dim_cols);
	assign take = (state_q == S_IDLE) && head_valid;
	assign pop = take;

	// saturating adds for the product and the trace
	assign mac_sum = {c_rd[CB-1], c_rd[CB-1:0]} + (CB+1)'(prod_q);
	assign mac_ovf = mac_sum[CB] != mac_sum[CB-1];
	assign mac_val = mac_ovf ? {mac_sum[CB], {(CB-1){~mac_sum[CB]}}} : mac_sum[CB-1:0];
	assign tr_sum = {sum_q[CB-1], sum_q} + {c_rd[CB-1], c_rd[CB-1:0]};
	assign tr_ovf = tr_sum[CB] != tr_sum[CB-1];
	assign tr_val = tr_ovf ? {tr_sum[CB], {(CB-1){~tr_sum[CB]}}} : tr_sum[CB-1:0];

	always_comb begin
		a_we = 1'b0;
		b_we = 1'b0;
		c_we = 1'b0;
		a_addr = {head_item.row, head_item.col};
		b_addr = {head_item.row, head_item.col};
		c_addr = {i_q[IB-1:0], j_q[IB-1:0]};
		a_wd = head_item.value;
		b_wd = head_item.value;
		c_wd = '0;
		case (state_q)
			S_CLR_ALL: begin
				a_we = 1'b1;
				b_we = 1'b1;
				c_we = 1'b1;
				a_addr = clr_q;
				b_addr = clr_q;
				c_addr = clr_q;
				a_wd = '0;
				b_wd = '0;
			end
			S_CLR_C: begin
				c_we = 1'b1;
				c_addr = clr_q;
			end
			S_IDLE: begin
				a_we = take && head_item.kind == smm_pkg::REQ_WR_A;
				b_we = take && head_item.kind == smm_pkg::REQ_WR_B;
			end
			S_MA, S_MA_W: a_addr = {i_q[IB-1:0], k_q[IB-1:0]};
			S_MB, S_MB_W: b_addr = {k_q[IB-1:0], j_q[IB-1:0]};
			S_MC: begin
				c_we = 1'b1;
				c_wd = {c_rd[CB] | mac_ovf, mac_val};
			end
			S_RD, S_RD_W: c_addr = {rrow_q, rcol_q};
			S_TR, S_TR_W: c_addr = {i_q[IB-1:0], i_q[IB-1:0]};
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (a_we) a_mem[a_addr] <= a_wd;
		a_rd <= a_mem[a_addr];
	end
	always_ff @(posedge clk) begin
		if (b_we) b_mem[b_addr] <= b_wd;
		b_rd <= b_mem[b_addr];
	end
	always_ff @(posedge clk) begin
		if (c_we) c_mem[c_addr] <= c_wd;
		c_rd <= c_mem[c_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR_ALL;
			clr_q <= '0;
			i_q <= '0;
			k_q <= '0;
			j_q <= '0;
			done_q <= 1'b0;
			rrow_q <= '0;
			rcol_q <= '0;
			av_q <= '0;
			prod_q <= '0;
			sum_q <= '0;
			hit_q <= 1'b0;
			res_q <= '0;
			sat_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLR_ALL, S_CLR_C: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						i_q <= '0;
						k_q <= '0;
						if (state_q == S_CLR_C && rows != '0 && cols != '0) begin
							state_q <= S_MA;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (take) begin
						rrow_q <= head_item.row;
						rcol_q <= head_item.col;
						i_q <= '0;
						sum_q <= '0;
						hit_q <= 1'b0;
						clr_q <= '0;
						case (head_item.kind)
							smm_pkg::REQ_MUL:   state_q <= S_CLR_C;
							smm_pkg::REQ_CLEAR: state_q <= S_CLR_ALL;
							smm_pkg::REQ_RD_C:  state_q <= S_RD;
							smm_pkg::REQ_TRACE: begin
								if (rows == '0) begin
									done_q <= 1'b1;
									res_q <= '0;
									sat_q <= 1'b0;
								end else begin
									state_q <= S_TR;
								end
							end
							default: ;
						endcase
					end
				end
				S_MA: state_q <= S_MA_W;
				S_MA_W: begin
					av_q <= a_rd;
					j_q <= '0;
					if (a_rd != '0) begin
						state_q <= S_MB;
					end else if (k_q + 1'b1 != cols) begin
						k_q <= k_q + 1'b1;
						state_q <= S_MA;
					end else if (i_q + 1'b1 != rows) begin
						i_q <= i_q + 1'b1;
						k_q <= '0;
						state_q <= S_MA;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MB: state_q <= S_MB_W;
				S_MB_W, S_MC: begin
					prod_q <= av_q * b_rd;
					if (state_q == S_MB_W && b_rd != '0) begin
						state_q <= S_MC;
					end else if (j_q + 1'b1 != cols) begin
						j_q <= j_q + 1'b1;
						state_q <= S_MB;
					end else if (k_q + 1'b1 != cols) begin
						k_q <= k_q + 1'b1;
						state_q <= S_MA;
					end else if (i_q + 1'b1 != rows) begin
						i_q <= i_q + 1'b1;
						k_q <= '0;
						state_q <= S_MA;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RD: state_q <= S_RD_W;
				S_RD_W: begin
					done_q <= 1'b1;
					res_q <= c_rd[CB-1:0];
					sat_q <= c_rd[CB];
					state_q <= S_IDLE;
				end
				S_TR: state_q <= S_TR_W;
				S_TR_W: begin
					sum_q <= tr_val;
					hit_q <= hit_q | tr_ovf | c_rd[CB];
					if (i_q + 1'b1 >= rows) begin
						done_q <= 1'b1;
						res_q <= tr_val;
						sat_q <= hit_q | tr_ovf | c_rd[CB];
						state_q <= S_IDLE;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_TR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign result_value = res_q;
	assign saturated = sat_q;

`include "sparse_matrix_multiply_trace_macros.svh"
	`SMM_ASSERT_NEXT(a_read_answers, clk, arst_n, state_q == S_RD_W, done)
	`SMM_ASSERT_IMP(a_pop_idle, clk, arst_n, pop, state_q == S_IDLE)
	`SMM_ASSERT_IMP(a_loop_bounds, clk, arst_n, state_q == S_MC,
		i_q < rows && k_q < cols && j_q < cols)
endmodule

[rtl/sparse_matrix_multiply_trace.sv]
// Sparse matrix engine with trace, Q2.14 elements and 48-bit saturating sums.
// Items enter on start while busy is low; req_type selects write A, write B,
// multiply, read C, read trace or clear, with row, col and value alongside.
// dim_rows and dim_cols are set through cfg_we, cfg_index and cfg_data.
// Reads of C and trace give one result, shown for one cycle with done high on
// result_value and saturated; the receiver cannot stall, so results never wait.
// Items pass a two-entry queue to the sequencer; busy is high while it is full.
// Element writes are done as the item leaves the queue. A read of C reads the
// store and registers the answer; a trace adds up the diagonal of C entry by
// entry. A multiply first sweeps C to zero, then reads each A entry in use, and
// for a nonzero A entry each B entry of the matching row, and adds the product
// of each nonzero pair into C; its run time is set by the single-port stores of
// A, B and C. A clear sweeps all three stores to zero.
// After reset the stores are swept to zero; items queue up meanwhile and
// configuration writes are taken at once.
// depends on smm_pkg, smm_front, smm_back
module sparse_matrix_multiply_trace (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [2:0]                         req_type,
	input  logic [smm_pkg::IdxBits-1:0]        row,
	input  logic [smm_pkg::IdxBits-1:0]        col,
	input  logic signed [smm_pkg::ElemBits-1:0] value,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [smm_pkg::DimBits-1:0]        cfg_data,
	output logic                               done,
	output logic signed [smm_pkg::AccBits-1:0] result_value,
	output logic                               saturated
);
	logic [smm_pkg::DimBits-1:0] rows_q, cols_q;
	smm_pkg::item_t in_item, head_item;
	logic head_valid, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= smm_pkg::DimBits'(smm_pkg::MaxDim);
			cols_q <= smm_pkg::DimBits'(smm_pkg::MaxDim);
		end else if (cfg_we) begin
			if (cfg_index == smm_pkg::CFG_ROWS) rows_q <= cfg_data;
			else cols_q <= cfg_data;
		end
	end

	assign in_item = '{kind: smm_pkg::req_t'(req_type), row: row, col: col, value: value};

	smm_front u_front (
		.clk(clk), .arst_n(arst_n), .push(start), .push_item(in_item), .pop(pop),
		.full(busy), .head_valid(head_valid), .head_item(head_item)
	);

	smm_back u_back (
		.clk(clk), .arst_n(arst_n), .head_valid(head_valid), .head_item(head_item),
		.pop(pop), .dim_rows(rows_q), .dim_cols(cols_q), .done(done),
		.result_value(result_value), .saturated(saturated)
	);
endmodule
